// File: rtl/eeg_pkg.sv
package eeg_pkg;

    localparam int OPERAND_BITS   = 63;
    localparam int COEFF_BITS     = 64;
    localparam int CNT_BITS       = $clog2(OPERAND_BITS);
    localparam int IN_TDATA_BITS  = ((2 * OPERAND_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = OPERAND_BITS + 2 * COEFF_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // take a new operand pair
        logic init;        // set up one division rp / rc
        logic align_step;  // shift divisor left by one
        logic div_step;    // one quotient bit
        logic update;      // rotate remainder and coefficients
        logic capture;     // move finished result to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic rc_zero;
        logic align_more;
        logic cnt_zero;
        logic out_valid;
    } t_status;

endpackage

// File: rtl/eeg_datapath.sv
module eeg_datapath (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  eeg_pkg::t_cmd                             i_cmd,
    output eeg_pkg::t_status                          o_status,
    input  logic [eeg_pkg::OPERAND_BITS-1:0]          i_a,
    input  logic [eeg_pkg::OPERAND_BITS-1:0]          i_b,
    input  logic                                      i_out_ready,
    output logic                                      o_out_valid,
    output logic [eeg_pkg::OPERAND_BITS-1:0]          o_gcd,
    output logic signed [eeg_pkg::COEFF_BITS-1:0]     o_coeff_u,
    output logic signed [eeg_pkg::COEFF_BITS-1:0]     o_coeff_v,
    output logic                                      o_coprime,
    output logic                                      o_zero_divisor
);

    localparam int OB = eeg_pkg::OPERAND_BITS;
    localparam int CB = eeg_pkg::COEFF_BITS;

    // Euclid state: remainders and Bezout coefficients (mod 2^CB)
    logic [OB-1:0] r_rp, r_rc;
    logic [CB-1:0] r_sp, r_sc, r_tp, r_tc;
    // shift-subtract divider
    logic [OB-1:0] r_rem, r_div;
    logic [CB-1:0] r_qs, r_qt;   // q*sc and q*tc, built MSB first
    logic [eeg_pkg::CNT_BITS-1:0] r_cnt;
    logic          r_zd;
    // output register
    logic          r_out_valid;
    logic [OB-1:0] r_out_gcd;
    logic [CB-1:0] r_out_u, r_out_v;
    logic          r_out_coprime, r_out_zd;

    logic [OB:0]   n_div_dbl;
    logic          n_qbit;
    logic [OB-1:0] n_rem;
    logic [CB-1:0] n_qs, n_qt;

    always_comb begin
        n_div_dbl = {r_div, 1'b0};
        n_qbit    = (r_div <= r_rem);
        n_rem     = n_qbit ? (r_rem - r_div) : r_rem;
        n_qs      = {r_qs[CB-2:0], 1'b0} + (n_qbit ? r_sc : '0);
        n_qt      = {r_qt[CB-2:0], 1'b0} + (n_qbit ? r_tc : '0);
    end

    always_comb begin
        o_status.rc_zero    = (r_rc == '0);
        o_status.align_more = (n_div_dbl <= {1'b0, r_rem});
        o_status.cnt_zero   = (r_cnt == '0);
        o_status.out_valid  = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rp <= i_a;
            r_rc <= i_b;
            r_sp <= CB'(1);
            r_sc <= '0;
            r_tp <= '0;
            r_tc <= CB'(1);
            r_zd <= (i_b == '0);
        end else if (i_cmd.update) begin
            r_rp <= r_rc;
            r_rc <= r_rem;
            r_sp <= r_sc;
            r_sc <= r_sp - r_qs;
            r_tp <= r_tc;
            r_tc <= r_tp - r_qt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_rem <= r_rp;
            r_div <= r_rc;
            r_qs  <= '0;
            r_qt  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.align_step) begin
            r_div <= n_div_dbl[OB-1:0];
            r_cnt <= r_cnt + eeg_pkg::CNT_BITS'(1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_div <= r_div >> 1;
            r_qs  <= n_qs;
            r_qt  <= n_qt;
            r_cnt <= r_cnt - eeg_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_gcd     <= r_rp;
            r_out_u       <= r_sp;
            r_out_v       <= r_tp;
            r_out_coprime <= (r_rp == OB'(1));
            r_out_zd      <= r_zd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gcd          = r_out_gcd;
    assign o_coeff_u      = r_out_u;
    assign o_coeff_v      = r_out_v;
    assign o_coprime      = r_out_coprime;
    assign o_zero_divisor = r_out_zd;

    // aligned divisor: partial remainder stays below twice the divisor
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ({1'b0, r_rem} < n_div_dbl))
        else $error("partial remainder out of range");

    // new remainder is smaller than the divisor
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> (r_rem < r_rc))
        else $error("remainder not below divisor");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

endmodule

// File: rtl/eeg_ctrl.sv
module eeg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    input  eeg_pkg::t_status i_status,
    output eeg_pkg::t_cmd    o_cmd
);

    eeg_pkg::t_state r_state, n_state;
    logic            n_out_free;

    assign n_out_free = !i_status.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eeg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eeg_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = eeg_pkg::ST_CHECK;
            end
            eeg_pkg::ST_CHECK: begin
                if (!i_status.rc_zero)  n_state = eeg_pkg::ST_ALIGN;
                else if (n_out_free)    n_state = eeg_pkg::ST_IDLE;
            end
            eeg_pkg::ST_ALIGN: begin
                if (!i_status.align_more) n_state = eeg_pkg::ST_DIVIDE;
            end
            eeg_pkg::ST_DIVIDE: begin
                if (i_status.cnt_zero) n_state = eeg_pkg::ST_UPDATE;
            end
            eeg_pkg::ST_UPDATE: begin
                n_state = eeg_pkg::ST_CHECK;
            end
            default: n_state = eeg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            eeg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            eeg_pkg::ST_CHECK: begin
                o_cmd.init    = !i_status.rc_zero;
                o_cmd.capture = i_status.rc_zero && n_out_free;
            end
            eeg_pkg::ST_ALIGN: begin
                o_cmd.align_step = i_status.align_more;
            end
            eeg_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            eeg_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == eeg_pkg::ST_CHECK))
        else $error("accepted transfer did not start a run");

    a_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eeg_pkg::ST_DIVIDE && i_status.cnt_zero)
            |=> (r_state == eeg_pkg::ST_UPDATE))
        else $error("division did not end after last quotient bit");

    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == eeg_pkg::ST_IDLE && i_status.out_valid))
        else $error("capture did not post result");

endmodule

// File: rtl/extended_euclid_gcd.sv
// Extended Euclid: gcd of two unsigned operands plus Bezout coefficients u, v
// with u*a + v*b = gcd (two's complement, exact).
//
// Input stream (s_axis): tdata = {pad, b, a}, a in the lowest bits. One
// transfer starts one run; tready is high only while no run is in progress.
// Output stream (m_axis): one transfer per input. tdata = {pad, v, u, gcd},
// tuser = {zero_divisor, coprime}. b == 0 gives gcd = a, u = 1, v = 0 with
// zero_divisor set.
//
// Each Euclid step is a shift-subtract divide: the divisor is first shifted up
// to the dividend (the last align step only compares), then k+1 quotient bits
// follow, one per cycle, with q*u and q*v built by shift-add alongside; the
// check and update states frame the step. The shifts k telescope to at most 63
// over a run. One item at a time.
//
// The result sits in an output register; once it is captured the block takes
// the next input while that result still waits. A stalled receiver holds the
// block only at the end of the following run. Synchronous reset clears the
// controller and the output valid flag.
module extended_euclid_gcd (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [eeg_pkg::IN_TDATA_BITS-1:0]    i_s_axis_tdata,  // a, b
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [eeg_pkg::OUT_TDATA_BITS-1:0]   o_m_axis_tdata,  // gcd, coeff_u, coeff_v
    output logic [eeg_pkg::OUT_TUSER_BITS-1:0]   o_m_axis_tuser   // coprime, zero_divisor
);

    localparam int OB = eeg_pkg::OPERAND_BITS;
    localparam int CB = eeg_pkg::COEFF_BITS;

    eeg_pkg::t_cmd    cmd;
    eeg_pkg::t_status status;

    logic [OB-1:0]        gcd;
    logic signed [CB-1:0] coeff_u, coeff_v;
    logic                 coprime, zero_divisor;

    eeg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    eeg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_a            (i_s_axis_tdata[OB-1:0]),
        .i_b            (i_s_axis_tdata[2*OB-1:OB]),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_gcd          (gcd),
        .o_coeff_u      (coeff_u),
        .o_coeff_v      (coeff_v),
        .o_coprime      (coprime),
        .o_zero_divisor (zero_divisor)
    );

    assign o_m_axis_tdata = eeg_pkg::OUT_TDATA_BITS'({coeff_v, coeff_u, gcd});
    assign o_m_axis_tuser = {zero_divisor, coprime};

endmodule
